@@ rtl/scfill_pkg.sv @@
// Shared types and constants for the scanline polygon span fill unit.
// Used by scfill_div and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package scfill_pkg;
	localparam int XW      = 10;
	localparam int VMAX    = 16;
	localparam int VIW     = $clog2(VMAX);
	localparam int VCW     = $clog2(VMAX + 1);
	localparam int MAX_RES = 8;
	localparam int PW      = $clog2(MAX_RES + 1);
	localparam int PRW     = 2 * XW;
	localparam int DCW     = $clog2(PRW + 1);

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_FILL  = 2'd2;
	// The remaining code is unused and the block ignores it.
	localparam logic [1:0] ACT_RSVD  = 2'd3;

	typedef struct packed {
		logic [1:0]    action;
		logic [XW-1:0] vertex_x;
		logic [XW-1:0] vertex_y;
		logic [XW-1:0] scan_y;
	} in_item_t;

	typedef struct packed {
		logic [XW-1:0] span_y;
		logic [XW-1:0] span_start;
		logic [XW:0]   span_end;
		logic          no_span;
		logic          overflow;
		logic          last;
	} out_item_t;

	typedef struct packed {
		logic          done;
		logic [PRW-1:0] quo;
		logic [XW-1:0]  rem;
	} div_res_t;
endpackage
`default_nettype wire

@@ rtl/scfill_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module scfill_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/scfill_div.sv @@
// Restoring divider, one quotient bit per cycle, for the edge crossing offset.
// Depends on scfill_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scfill_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [scfill_pkg::PRW-1:0] dividend,
	input  wire logic [scfill_pkg::XW-1:0]  divisor,
	output scfill_pkg::div_res_t            res
);
	logic [scfill_pkg::PRW-1:0] a_q;
	logic [scfill_pkg::XW-1:0]  r_q;
	logic [scfill_pkg::XW-1:0]  d_q;
	logic [scfill_pkg::DCW-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [scfill_pkg::XW:0]    trial;
	logic [scfill_pkg::XW:0]    diff;

	assign trial = {r_q, a_q[scfill_pkg::PRW-1]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			r_q    <= '0;
			d_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= dividend;
				r_q    <= '0;
				d_q    <= divisor;
				cnt_q  <= scfill_pkg::DCW'(scfill_pkg::PRW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// The partial remainder stays below the divisor, so it fits in XW bits.
				if (trial >= {1'b0, d_q}) begin
					r_q <= diff[scfill_pkg::XW-1:0];
					a_q <= {a_q[scfill_pkg::PRW-2:0], 1'b1};
				end else begin
					r_q <= trial[scfill_pkg::XW-1:0];
					a_q <= {a_q[scfill_pkg::PRW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == scfill_pkg::DCW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.quo  = a_q;
	assign res.rem  = r_q;
endmodule
`default_nettype wire

@@ rtl/scanline_polygon_span_fill_unit.sv @@
// Scanline polygon span fill: top level with vertex store, crossing store and sequencer.
// Depends on scfill_pkg, scfill_ram and scfill_div.
`timescale 1ns / 1ps
`default_nettype none
// Clear and add-vertex beats give no result. A fill beat walks each polygon edge
// through the vertex RAM; for each edge that crosses the row the offset is multiplied,
// divided in the bit-serial divider and inserted into the sorted crossing RAM, each
// larger entry being shifted up after a compare. Each span then needs reads of its two
// crossings from the crossing RAM and a load of the result register.
// A result beat may wait at the output while the next input beat is accepted.
module scanline_polygon_span_fill_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire scfill_pkg::in_item_t  in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output scfill_pkg::out_item_t      out_data
);
	localparam int XW  = scfill_pkg::XW;
	localparam int VIW = scfill_pkg::VIW;
	localparam int VCW = scfill_pkg::VCW;
	localparam int PW  = scfill_pkg::PW;

	typedef enum logic [3:0] {
		S_IDLE, S_VRD0, S_VWAIT0, S_ERD, S_EWAIT, S_MUL, S_DSTART, S_DIV,
		S_INS, S_INSW, S_NEXT, S_OSTART, S_ORD0, S_ORD1, S_ORD2, S_EMIT
	} state_t;

	state_t               state_q;
	logic [VCW-1:0]       cnt_q;
	logic                 ovf_q;
	logic [XW-1:0]        sy_q;
	logic [2*XW-1:0]      prev_q;
	logic [2*XW-1:0]      cur_q;
	logic [VIW-1:0]       e_q;
	logic [VCW-1:0]       k_q;
	logic [VCW-1:0]       j_q;
	logic [XW-1:0]        xa_q;
	logic                 neg_q;
	logic [XW-1:0]        adx_q;
	logic [XW-1:0]        t_q;
	logic [XW-1:0]        dy_q;
	logic [2*XW-1:0]      prod_q;
	logic [XW-1:0]        v_q;
	logic [PW-1:0]        pairs_q;
	logic [PW-1:0]        p_q;
	logic [XW-1:0]        s_q;
	logic [XW-1:0]        end_q;
	logic                 nospan_q;
	logic                 out_valid_q;
	scfill_pkg::out_item_t out_q;

	logic                 in_acc;
	logic                 out_free;
	logic                 load_out;
	logic                 v_we;
	logic [VIW-1:0]       v_raddr;
	logic [2*XW-1:0]      v_rdata;
	logic                 c_we;
	logic [VIW-1:0]       c_waddr;
	logic [XW-1:0]        c_wdata;
	logic [VIW-1:0]       c_raddr;
	logic [XW-1:0]        c_rdata;
	logic                 div_start;
	scfill_pkg::div_res_t div_res;
	logic [XW-1:0]        py, cy, px, cx;
	logic                 crosses;
	logic                 prev_low;
	logic [VCW-1:0]       e_next;
	logic [VCW-1:0]       half_k;
	logic [XW-1:0]        x_cross;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign px = prev_q[2*XW-1:XW];
	assign py = prev_q[XW-1:0];
	assign cx = v_rdata[2*XW-1:XW];
	assign cy = v_rdata[XW-1:0];
	assign crosses  = (py <= sy_q && cy > sy_q) || (py > sy_q && cy <= sy_q);
	assign prev_low = (py < cy);
	assign e_next   = VCW'(e_q) + 1'b1;
	assign half_k   = k_q >> 1;

	// Floor of the exact crossing: a negative slope rounds the offset away from xa.
	always_comb begin
		if (neg_q) begin
			x_cross = xa_q - div_res.quo[XW-1:0] - XW'(div_res.rem != '0);
		end else begin
			x_cross = xa_q + div_res.quo[XW-1:0];
		end
	end

	assign v_we = in_acc && in_data.action == scfill_pkg::ACT_ADD
		&& cnt_q < VCW'(scfill_pkg::VMAX);

	always_comb begin
		v_raddr = '0;
		if (state_q == S_ERD) begin
			v_raddr = (e_next < cnt_q) ? e_next[VIW-1:0] : '0;
		end
	end

	always_comb begin
		c_we      = 1'b0;
		c_waddr   = j_q[VIW-1:0];
		c_wdata   = v_q;
		c_raddr   = '0;
		div_start = (state_q == S_DSTART);
		load_out  = 1'b0;
		unique case (state_q)
			S_INS: begin
				if (j_q == '0) begin
					c_we = 1'b1;
				end else begin
					c_raddr = VIW'(j_q - 1'b1);
				end
			end
			S_INSW: begin
				c_we = 1'b1;
				if (c_rdata > v_q) begin
					c_wdata = c_rdata;
				end
			end
			S_ORD0: c_raddr = VIW'({p_q, 1'b0});
			S_ORD1: c_raddr = VIW'({p_q, 1'b1});
			S_EMIT: load_out = out_free;
			default: ;
		endcase
	end

	scfill_ram #(.W(2 * XW), .D(scfill_pkg::VMAX)) u_vram (
		.clk   (clk),
		.we    (v_we),
		.waddr (cnt_q[VIW-1:0]),
		.wdata ({in_data.vertex_x, in_data.vertex_y}),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	scfill_ram #(.W(XW), .D(scfill_pkg::VMAX)) u_cram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	scfill_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (dy_q),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			sy_q        <= '0;
			prev_q      <= '0;
			cur_q       <= '0;
			e_q         <= '0;
			k_q         <= '0;
			j_q         <= '0;
			xa_q        <= '0;
			neg_q       <= 1'b0;
			adx_q       <= '0;
			t_q         <= '0;
			dy_q        <= '0;
			prod_q      <= '0;
			v_q         <= '0;
			pairs_q     <= '0;
			p_q         <= '0;
			s_q         <= '0;
			end_q       <= '0;
			nospan_q    <= 1'b0;
			out_q       <= '0;
		end else begin
			if (load_out) begin
				out_valid_q      <= 1'b1;
				out_q.span_y     <= sy_q;
				out_q.overflow   <= ovf_q;
				out_q.no_span    <= nospan_q;
				out_q.span_start <= nospan_q ? '0 : s_q;
				out_q.span_end   <= nospan_q ? '0 : ({1'b0, end_q} + 1'b1);
				out_q.last       <= nospan_q || (PW'(p_q + 1'b1) == pairs_q);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (in_data.action)
							scfill_pkg::ACT_CLEAR: begin
								cnt_q <= '0;
								ovf_q <= 1'b0;
							end
							scfill_pkg::ACT_ADD: begin
								if (cnt_q < VCW'(scfill_pkg::VMAX)) begin
									cnt_q <= cnt_q + 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							scfill_pkg::ACT_FILL: begin
								sy_q     <= in_data.scan_y;
								k_q      <= '0;
								e_q      <= '0;
								nospan_q <= 1'b0;
								state_q  <= (cnt_q < VCW'(2)) ? S_OSTART : S_VRD0;
							end
							default: ;
						endcase
					end
				end
				S_VRD0:   state_q <= S_VWAIT0;
				S_VWAIT0: begin
					prev_q  <= v_rdata;
					state_q <= S_ERD;
				end
				S_ERD:    state_q <= S_EWAIT;
				S_EWAIT: begin
					cur_q <= v_rdata;
					if (crosses) begin
						// Orient the edge so that it runs upward from its lower endpoint.
						if (prev_low) begin
							xa_q  <= px;
							neg_q <= cx < px;
							adx_q <= (cx < px) ? px - cx : cx - px;
							t_q   <= sy_q - py;
							dy_q  <= cy - py;
						end else begin
							xa_q  <= cx;
							neg_q <= px < cx;
							adx_q <= (px < cx) ? cx - px : px - cx;
							t_q   <= sy_q - cy;
							dy_q  <= py - cy;
						end
						state_q <= S_MUL;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_MUL: begin
					prod_q  <= adx_q * t_q;
					state_q <= S_DSTART;
				end
				S_DSTART: state_q <= S_DIV;
				S_DIV: begin
					if (div_res.done) begin
						v_q     <= x_cross;
						j_q     <= k_q;
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (j_q == '0) begin
						if (k_q < VCW'(scfill_pkg::VMAX)) begin
							k_q <= k_q + 1'b1;
						end
						state_q <= S_NEXT;
					end else begin
						state_q <= S_INSW;
					end
				end
				S_INSW: begin
					if (c_rdata > v_q) begin
						j_q     <= j_q - 1'b1;
						state_q <= S_INS;
					end else begin
						if (k_q < VCW'(scfill_pkg::VMAX)) begin
							k_q <= k_q + 1'b1;
						end
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					prev_q <= cur_q;
					if (e_next == cnt_q) begin
						state_q <= S_OSTART;
					end else begin
						e_q     <= e_q + 1'b1;
						state_q <= S_ERD;
					end
				end
				S_OSTART: begin
					p_q <= '0;
					if (half_k > VCW'(scfill_pkg::MAX_RES)) begin
						pairs_q <= PW'(scfill_pkg::MAX_RES);
					end else begin
						pairs_q <= PW'(half_k);
					end
					if (half_k == '0) begin
						nospan_q <= 1'b1;
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_ORD0;
					end
				end
				S_ORD0: state_q <= S_ORD1;
				S_ORD1: begin
					s_q     <= c_rdata;
					state_q <= S_ORD2;
				end
				S_ORD2: begin
					end_q   <= c_rdata;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (nospan_q || PW'(p_q + 1'b1) == pairs_q) begin
							state_q <= S_IDLE;
						end else begin
							p_q     <= p_q + 1'b1;
							state_q <= S_ORD0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == S_DIV)
		else $error("divider finished outside the divide wait");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || out_ready))
		else $error("result register loaded while a beat was pending");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= VCW'(scfill_pkg::VMAX))
		else $error("vertex count beyond capacity");
	a_edge_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ERD |-> e_next < cnt_q || e_next == cnt_q)
		else $error("edge walk ran past the vertex count");
	a_crossings_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_NEXT |=> k_q <= VCW'(e_q) + 1'b1 || state_q == S_OSTART)
		else $error("more crossings than edges walked");
endmodule
`default_nettype wire
